FILE: hw/rtl/wsp_pkg.sv
// Shared types and constants for the world-to-screen projection pipeline.
package wsp_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int COORD_W      = 32;
  localparam int PROD_W       = 2 * COORD_W;
  localparam int TERM_W       = PROD_W - FRAC_BITS;
  localparam int CLIP_W       = PROD_W + 1 - FRAC_BITS;
  localparam int MAG_W        = CLIP_W - 1;
  localparam int NDC_INT_BITS = 17;
  localparam int QB           = NDC_INT_BITS + FRAC_BITS;
  localparam int NDC_W        = QB + 1;
  localparam int OFFS_W       = QB + 2;
  localparam int DIM_W        = 16;
  localparam int PIX_W        = 16;
  localparam int PIXP_W       = OFFS_W + DIM_W + 1;
  localparam int SHR_W        = PIXP_W - FRAC_BITS - 1;
  localparam int W_MIN        = ((1 << FRAC_BITS) + 999) / 1000;
  localparam int PIX_MAX      = (1 << (PIX_W - 1)) - 1;
  localparam int PIX_MIN      = -(1 << (PIX_W - 1));
  localparam int CFG_IDX_W    = 4;
  localparam int CFG_DATA_W   = 64;

  localparam logic [NDC_W-1:0]         NDC_LIM = {1'b1, {QB{1'b0}}};
  localparam logic signed [OFFS_W-1:0] ONE_Q   = {{(OFFS_W-FRAC_BITS-1){1'b0}}, 1'b1,
                                                  {FRAC_BITS{1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_X_XY      = 4'd0,
    REG_ROW_X_ZT      = 4'd1,
    REG_ROW_Y_XY      = 4'd2,
    REG_ROW_Y_ZT      = 4'd3,
    REG_ROW_W_XY      = 4'd4,
    REG_ROW_W_ZT      = 4'd5,
    REG_SCREEN_DIMS   = 4'd6,
    REG_MATRIX_LOADED = 4'd7
  } wsp_reg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] t;
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } wsp_row_t;

  typedef struct packed {
    wsp_row_t w;
    wsp_row_t y;
    wsp_row_t x;
  } wsp_mat_t;

  typedef struct packed {
    logic loaded;
    logic behind;
    logic neg_x;
    logic neg_y;
  } wsp_side_t;

  typedef struct packed {
    logic signed [PIX_W-1:0] sx;
    logic signed [PIX_W-1:0] sy;
    logic                    on;
  } wsp_res_t;

endpackage

FILE: hw/rtl/wsp_dot.sv
// Two-stage matrix row dot products: registered products, then clip sums.
module wsp_dot (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic signed [wsp_pkg::COORD_W-1:0] pos_x,
  input  logic signed [wsp_pkg::COORD_W-1:0] pos_y,
  input  logic signed [wsp_pkg::COORD_W-1:0] pos_z,
  input  wsp_pkg::wsp_mat_t                  mat,
  output logic                               clip_valid,
  output logic signed [wsp_pkg::CLIP_W-1:0]  clip_x,
  output logic signed [wsp_pkg::CLIP_W-1:0]  clip_y,
  output logic signed [wsp_pkg::CLIP_W-1:0]  clip_w
);
  import wsp_pkg::*;

  wsp_row_t                  rows     [3];
  logic signed [COORD_W-1:0] pos      [3];
  logic signed [PROD_W-1:0]  prod     [3][3];
  logic signed [TERM_W-1:0]  term_nxt [3][3];
  logic signed [TERM_W-1:0]  term_r   [3][3];
  logic signed [CLIP_W-1:0]  clip_nxt [3];
  logic signed [CLIP_W-1:0]  clip_r   [3];
  logic                      v1_r;
  logic                      v2_r;

  always_comb begin
    rows[0] = mat.x;
    rows[1] = mat.y;
    rows[2] = mat.w;
    pos[0]  = pos_x;
    pos[1]  = pos_y;
    pos[2]  = pos_z;
    for (int r = 0; r < 3; r++) begin
      prod[r][0] = PROD_W'(rows[r].x) * PROD_W'(pos[0]);
      prod[r][1] = PROD_W'(rows[r].y) * PROD_W'(pos[1]);
      prod[r][2] = PROD_W'(rows[r].z) * PROD_W'(pos[2]);
      for (int c = 0; c < 3; c++) begin
        term_nxt[r][c] = TERM_W'(prod[r][c] >>> FRAC_BITS);
      end
      clip_nxt[r] = CLIP_W'(term_r[r][0]) + CLIP_W'(term_r[r][1]) +
                    CLIP_W'(term_r[r][2]) + CLIP_W'(rows[r].t);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      term_r <= term_nxt;
      clip_r <= clip_nxt;
    end
  end

  assign clip_valid = v2_r;
  assign clip_x     = clip_r[0];
  assign clip_y     = clip_r[1];
  assign clip_w     = clip_r[2];

endmodule

FILE: hw/rtl/wsp_div.sv
// Pipelined restoring divider forming the clamped ndc magnitudes, one bit per stage.
module wsp_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              clip_valid,
  input  logic signed [wsp_pkg::CLIP_W-1:0] clip_x,
  input  logic signed [wsp_pkg::CLIP_W-1:0] clip_y,
  input  logic signed [wsp_pkg::CLIP_W-1:0] clip_w,
  input  logic                              loaded,
  output logic                              ndc_valid,
  output logic [wsp_pkg::NDC_W-1:0]         ndc_x,
  output logic [wsp_pkg::NDC_W-1:0]         ndc_y,
  output wsp_pkg::wsp_side_t                side
);
  import wsp_pkg::*;

  logic                v_r    [QB+1];
  logic [MAG_W-1:0]    rx_r   [QB+1];
  logic [MAG_W-1:0]    ry_r   [QB+1];
  logic [QB-1:0]       lx_r   [QB+1];
  logic [QB-1:0]       ly_r   [QB+1];
  logic [QB-1:0]       qx_r   [QB+1];
  logic [QB-1:0]       qy_r   [QB+1];
  logic                ovx_r  [QB+1];
  logic                ovy_r  [QB+1];
  logic [MAG_W-1:0]    d_r    [QB+1];
  wsp_side_t           side_r [QB+1];

  logic [MAG_W:0]      tx     [QB];
  logic [MAG_W:0]      ty     [QB];
  logic                gex    [QB];
  logic                gey    [QB];
  logic [MAG_W-1:0]    rx_nxt [QB];
  logic [MAG_W-1:0]    ry_nxt [QB];
  logic                ovx_nxt[QB];
  logic                ovy_nxt[QB];

  logic [MAG_W-1:0]    nx;
  logic [MAG_W-1:0]    ny;
  wsp_side_t           side_nxt;

  function automatic logic [MAG_W-1:0] mag(input logic signed [CLIP_W-1:0] v);
    mag = v[CLIP_W-1] ? MAG_W'(-v) : MAG_W'(v);
  endfunction

  always_comb begin
    nx              = mag(clip_x);
    ny              = mag(clip_y);
    side_nxt.loaded = loaded;
    side_nxt.behind = clip_w < $signed(CLIP_W'(W_MIN));
    side_nxt.neg_x  = clip_x[CLIP_W-1];
    side_nxt.neg_y  = clip_y[CLIP_W-1];
  end

  always_comb begin
    for (int k = 0; k < QB; k++) begin
      tx[k]      = {rx_r[k], lx_r[k][QB-1]};
      ty[k]      = {ry_r[k], ly_r[k][QB-1]};
      gex[k]     = tx[k] >= {1'b0, d_r[k]};
      gey[k]     = ty[k] >= {1'b0, d_r[k]};
      rx_nxt[k]  = gex[k] ? MAG_W'(tx[k] - {1'b0, d_r[k]}) : MAG_W'(tx[k]);
      ry_nxt[k]  = gey[k] ? MAG_W'(ty[k] - {1'b0, d_r[k]}) : MAG_W'(ty[k]);
      ovx_nxt[k] = (k == 0) ? (rx_r[k] >= d_r[k]) : ovx_r[k];
      ovy_nxt[k] = (k == 0) ? (ry_r[k] >= d_r[k]) : ovy_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= QB; k++) begin
        v_r[k] <= 1'b0;
      end
    end else if (en) begin
      v_r[0] <= clip_valid;
      for (int k = 0; k < QB; k++) begin
        v_r[k+1] <= v_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rx_r[0]   <= MAG_W'(nx >> NDC_INT_BITS);
      ry_r[0]   <= MAG_W'(ny >> NDC_INT_BITS);
      lx_r[0]   <= {nx[NDC_INT_BITS-1:0], {FRAC_BITS{1'b0}}};
      ly_r[0]   <= {ny[NDC_INT_BITS-1:0], {FRAC_BITS{1'b0}}};
      qx_r[0]   <= '0;
      qy_r[0]   <= '0;
      ovx_r[0]  <= 1'b0;
      ovy_r[0]  <= 1'b0;
      d_r[0]    <= MAG_W'(clip_w);
      side_r[0] <= side_nxt;
      for (int k = 0; k < QB; k++) begin
        rx_r[k+1]   <= rx_nxt[k];
        ry_r[k+1]   <= ry_nxt[k];
        lx_r[k+1]   <= lx_r[k] << 1;
        ly_r[k+1]   <= ly_r[k] << 1;
        qx_r[k+1]   <= {qx_r[k][QB-2:0], gex[k]};
        qy_r[k+1]   <= {qy_r[k][QB-2:0], gey[k]};
        ovx_r[k+1]  <= ovx_nxt[k];
        ovy_r[k+1]  <= ovy_nxt[k];
        d_r[k+1]    <= d_r[k];
        side_r[k+1] <= side_r[k];
      end
    end
  end

  assign ndc_valid = v_r[QB];
  assign ndc_x     = ovx_r[QB] ? NDC_LIM : {1'b0, qx_r[QB]};
  assign ndc_y     = ovy_r[QB] ? NDC_LIM : {1'b0, qy_r[QB]};
  assign side      = side_r[QB];

endmodule

FILE: hw/rtl/wsp_pix.sv
// Viewport mapping: offset, scale by screen size, truncate and saturate to pixels.
module wsp_pix (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      ndc_valid,
  input  logic [wsp_pkg::NDC_W-1:0] ndc_x,
  input  logic [wsp_pkg::NDC_W-1:0] ndc_y,
  input  wsp_pkg::wsp_side_t        side,
  input  logic [2*wsp_pkg::DIM_W-1:0] dims,
  output logic                      pix_valid,
  output wsp_pkg::wsp_res_t         res
);
  import wsp_pkg::*;

  logic                     v_r [3];
  wsp_side_t                side1_r;
  wsp_side_t                side2_r;
  logic signed [OFFS_W-1:0] offs_x_r;
  logic signed [OFFS_W-1:0] offs_y_r;
  logic signed [OFFS_W-1:0] offs_x_nxt;
  logic signed [OFFS_W-1:0] offs_y_nxt;
  logic signed [OFFS_W-1:0] nx_s;
  logic signed [OFFS_W-1:0] ny_s;
  logic signed [PIXP_W-1:0] px_r;
  logic signed [PIXP_W-1:0] py_r;
  logic signed [PIXP_W-1:0] px_nxt;
  logic signed [PIXP_W-1:0] py_nxt;
  logic signed [PIXP_W-1:0] wd_s;
  logic signed [PIXP_W-1:0] ht_s;
  wsp_res_t                 res_r;
  wsp_res_t                 res_nxt;

  function automatic logic signed [PIX_W-1:0] to_pix(input logic signed [PIXP_W-1:0] p);
    logic signed [PIXP_W-1:0] a;
    logic signed [SHR_W-1:0]  s;
    a = p[PIXP_W-1] ? p + PIXP_W'((1 << (FRAC_BITS + 1)) - 1) : p;
    s = SHR_W'(a >>> (FRAC_BITS + 1));
    if (s > $signed(SHR_W'(PIX_MAX))) begin
      to_pix = PIX_W'(PIX_MAX);
    end else if (s < $signed(SHR_W'(PIX_MIN))) begin
      to_pix = PIX_W'(PIX_MIN);
    end else begin
      to_pix = PIX_W'(s);
    end
  endfunction

  always_comb begin
    nx_s       = $signed(OFFS_W'(ndc_x));
    ny_s       = $signed(OFFS_W'(ndc_y));
    offs_x_nxt = side.neg_x ? ONE_Q - nx_s : ONE_Q + nx_s;
    offs_y_nxt = side.neg_y ? ONE_Q + ny_s : ONE_Q - ny_s;
    wd_s       = PIXP_W'($signed({1'b0, dims[DIM_W-1:0]}));
    ht_s       = PIXP_W'($signed({1'b0, dims[2*DIM_W-1:DIM_W]}));
    px_nxt     = PIXP_W'(offs_x_r) * wd_s;
    py_nxt     = PIXP_W'(offs_y_r) * ht_s;
    if (!side2_r.loaded) begin
      res_nxt.sx = '0;
      res_nxt.sy = '0;
      res_nxt.on = 1'b0;
    end else if (side2_r.behind) begin
      res_nxt.sx = '1;
      res_nxt.sy = '1;
      res_nxt.on = 1'b0;
    end else begin
      res_nxt.sx = to_pix(px_r);
      res_nxt.sy = to_pix(py_r);
      res_nxt.on = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
      v_r[1] <= 1'b0;
      v_r[2] <= 1'b0;
    end else if (en) begin
      v_r[0] <= ndc_valid;
      v_r[1] <= v_r[0];
      v_r[2] <= v_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      offs_x_r <= offs_x_nxt;
      offs_y_r <= offs_y_nxt;
      side1_r  <= side;
      px_r     <= px_nxt;
      py_r     <= py_nxt;
      side2_r  <= side1_r;
      res_r    <= res_nxt;
    end
  end

  assign pix_valid = v_r[2];
  assign res       = res_r;

endmodule

FILE: hw/rtl/world_to_screen_projection.sv
// Top level of the world-to-screen projection: registers, pipeline and output buffer.
// One world point can be accepted every cycle unless input is refused. Its result reaches
// the output through these pipeline stages: two stages form the matrix dot products, one
// takes magnitudes, 33 stages of the restoring divider produce one ndc quotient bit
// each, and three stages map to pixels. A two-entry output buffer holds finished
// results; input is refused only while both entries are full. Configuration writes
// are always ready and take effect at once, so they belong in idle periods.
module world_to_screen_projection (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [wsp_pkg::COORD_W-1:0]    in_pos_x,
  input  logic signed [wsp_pkg::COORD_W-1:0]    in_pos_y,
  input  logic signed [wsp_pkg::COORD_W-1:0]    in_pos_z,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [wsp_pkg::PIX_W-1:0]      out_screen_x,
  output logic signed [wsp_pkg::PIX_W-1:0]      out_screen_y,
  output logic                                  out_on_screen,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [wsp_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [wsp_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import wsp_pkg::*;

  wsp_mat_t                 mat_r;
  logic [2*DIM_W-1:0]       dims_r;
  logic                     loaded_r;

  logic                     en;
  logic                     clip_valid;
  logic signed [CLIP_W-1:0] clip_x;
  logic signed [CLIP_W-1:0] clip_y;
  logic signed [CLIP_W-1:0] clip_w;
  logic                     ndc_valid;
  logic [NDC_W-1:0]         ndc_x;
  logic [NDC_W-1:0]         ndc_y;
  wsp_side_t                side;
  logic                     pix_valid;
  wsp_res_t                 res;

  wsp_res_t                 ob0_r;
  wsp_res_t                 ob1_r;
  wsp_res_t                 ob0_nxt;
  wsp_res_t                 ob1_nxt;
  logic [1:0]               ob_cnt_r;
  logic [1:0]               ob_cnt_nxt;
  logic                     push;
  logic                     pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mat_r    <= '0;
      dims_r   <= '0;
      loaded_r <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ROW_X_XY: begin
          mat_r.x.y <= cfg_data[2*COORD_W-1:COORD_W];
          mat_r.x.x <= cfg_data[COORD_W-1:0];
        end
        REG_ROW_X_ZT: begin
          mat_r.x.t <= cfg_data[2*COORD_W-1:COORD_W];
          mat_r.x.z <= cfg_data[COORD_W-1:0];
        end
        REG_ROW_Y_XY: begin
          mat_r.y.y <= cfg_data[2*COORD_W-1:COORD_W];
          mat_r.y.x <= cfg_data[COORD_W-1:0];
        end
        REG_ROW_Y_ZT: begin
          mat_r.y.t <= cfg_data[2*COORD_W-1:COORD_W];
          mat_r.y.z <= cfg_data[COORD_W-1:0];
        end
        REG_ROW_W_XY: begin
          mat_r.w.y <= cfg_data[2*COORD_W-1:COORD_W];
          mat_r.w.x <= cfg_data[COORD_W-1:0];
        end
        REG_ROW_W_ZT: begin
          mat_r.w.t <= cfg_data[2*COORD_W-1:COORD_W];
          mat_r.w.z <= cfg_data[COORD_W-1:0];
        end
        REG_SCREEN_DIMS: begin
          dims_r <= cfg_data[2*DIM_W-1:0];
        end
        REG_MATRIX_LOADED: begin
          loaded_r <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  assign en       = (ob_cnt_r != 2'd2);
  assign in_ready = en;

  wsp_dot u_dot (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (in_valid),
    .pos_x      (in_pos_x),
    .pos_y      (in_pos_y),
    .pos_z      (in_pos_z),
    .mat        (mat_r),
    .clip_valid (clip_valid),
    .clip_x     (clip_x),
    .clip_y     (clip_y),
    .clip_w     (clip_w)
  );

  wsp_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .clip_valid (clip_valid),
    .clip_x     (clip_x),
    .clip_y     (clip_y),
    .clip_w     (clip_w),
    .loaded     (loaded_r),
    .ndc_valid  (ndc_valid),
    .ndc_x      (ndc_x),
    .ndc_y      (ndc_y),
    .side       (side)
  );

  wsp_pix u_pix (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .ndc_valid (ndc_valid),
    .ndc_x     (ndc_x),
    .ndc_y     (ndc_y),
    .side      (side),
    .dims      (dims_r),
    .pix_valid (pix_valid),
    .res       (res)
  );

  assign push = pix_valid & en;
  assign pop  = out_valid & out_ready;

  always_comb begin
    ob0_nxt    = ob0_r;
    ob1_nxt    = ob1_r;
    ob_cnt_nxt = ob_cnt_r;
    if (push && pop) begin
      ob0_nxt = res;
    end else if (push) begin
      if (ob_cnt_r == 2'd0) begin
        ob0_nxt = res;
      end else begin
        ob1_nxt = res;
      end
      ob_cnt_nxt = ob_cnt_r + 2'd1;
    end else if (pop) begin
      ob0_nxt    = ob1_r;
      ob_cnt_nxt = ob_cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_cnt_r <= 2'd0;
    end else begin
      ob_cnt_r <= ob_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ob0_r <= ob0_nxt;
    ob1_r <= ob1_nxt;
  end

  assign out_valid     = (ob_cnt_r != 2'd0);
  assign out_screen_x  = ob0_r.sx;
  assign out_screen_y  = ob0_r.sy;
  assign out_on_screen = ob0_r.on;

`ifndef SYNTHESIS
  a_ob_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ob_cnt_r != 2'd3)
    else $error("output buffer count out of range");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input refused while no result is waiting");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(pix_valid))
    else $error("pipeline moved during a stall");
`endif

endmodule
